### design/cmeu_pkg.sv
// Package: types and constants shared by the momentum and energy update block.
package cmeu_pkg;
	localparam int unsigned FSUM_W = 36;
	localparam int unsigned PSUM_W = 40;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned MASS_W = 31;
	localparam int unsigned SW_W = 17;
	localparam int unsigned DT_W = 31;
	localparam int unsigned CFG_W = 31;
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_STAGE_WEIGHT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 1'd1;

	typedef struct packed {
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] force_z;
		logic signed [31:0] node_vel_x;
		logic signed [31:0] node_vel_y;
		logic signed [31:0] node_vel_z;
		logic [30:0] cell_mass;
		logic signed [31:0] old_vel_x;
		logic signed [31:0] old_vel_y;
		logic signed [31:0] old_vel_z;
		logic signed [31:0] old_total_energy;
		logic last_corner;
	} corner_t;

	typedef struct packed {
		logic signed [31:0] new_vel_x;
		logic signed [31:0] new_vel_y;
		logic signed [31:0] new_vel_z;
		logic signed [31:0] new_total_energy;
		logic signed [31:0] cell_power_out;
		logic [30:0] kinetic_energy;
		logic signed [31:0] internal_energy;
	} result_t;

	// element job handed from accumulator to update engine
	typedef struct packed {
		logic signed [FSUM_W-1:0] fsum_x;
		logic signed [FSUM_W-1:0] fsum_y;
		logic signed [FSUM_W-1:0] fsum_z;
		logic signed [PSUM_W-1:0] psum;
		logic [MASS_W-1:0] mass;
		logic signed [31:0] old_vel_x;
		logic signed [31:0] old_vel_y;
		logic signed [31:0] old_vel_z;
		logic signed [31:0] old_te;
	} job_t;
endpackage

### design/cmeu_if.sv
// Interfaces: valid/ready channels for corner items and results.
interface cmeu_corner_if;
	logic valid;
	logic ready;
	cmeu_pkg::corner_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface cmeu_result_if;
	logic valid;
	logic ready;
	cmeu_pkg::result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### design/cell_momentum_energy_update_core.sv
// Top level: config registers, corner accumulator front end, update back end.
//  channel | dir | payload
//  in_ch   | in  | corner_t: force, node velocity, element data, last_corner
//  out_ch  | out | result_t: velocity, energies, power
//  cfg     | in  | cfg_we, cfg_idx, cfg_data
// Non-last corners transfer one per cycle into the accumulator.
// A last corner hands one element job to the back end; its result follows a 47-bit
// serial divide of dt by mass, then a split multiply and an add for each of four lanes,
// the squaring of the three velocities, and the kinetic and internal energy steps.
// A second last corner stalls until the back end frees the job register.
// Reset clears the sums and the weight and step registers to 1.0.
module cell_momentum_energy_update_core (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [cmeu_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [cmeu_pkg::CFG_W-1:0] cfg_data,
	cmeu_corner_if.sink in_ch,
	cmeu_result_if.source out_ch
);
	logic [cmeu_pkg::SW_W-1:0] sw_q;
	logic [cmeu_pkg::DT_W-1:0] dt_q;
	logic job_valid;
	logic job_ready;
	cmeu_pkg::job_t job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= cmeu_pkg::SW_W'(65536);
			dt_q <= cmeu_pkg::DT_W'(65536);
		end else if (cfg_we) begin
			case (cfg_idx)
				cmeu_pkg::REG_STAGE_WEIGHT: sw_q <= cfg_data[cmeu_pkg::SW_W-1:0];
				cmeu_pkg::REG_TIME_STEP: dt_q <= cfg_data[cmeu_pkg::DT_W-1:0];
				default: ;
			endcase
		end
	end

	cmeu_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.job_valid(job_valid), .job_ready(job_ready), .job(job)
	);

	cmeu_back u_back (
		.clk(clk), .arst_n(arst_n), .stage_weight(sw_q), .time_step(dt_q),
		.job_valid(job_valid), .job_ready(job_ready), .job(job), .out_ch(out_ch)
	);
endmodule

### design/cmeu_front.sv
// Front end: per-corner force and power accumulation, emits element jobs.
module cmeu_front (
	input  logic clk,
	input  logic arst_n,
	cmeu_corner_if.sink in_ch,
	output logic job_valid,
	input  logic job_ready,
	output cmeu_pkg::job_t job
);
	logic signed [cmeu_pkg::FSUM_W-1:0] fsum_q [3];
	logic signed [cmeu_pkg::PSUM_W-1:0] psum_q;
	logic signed [cmeu_pkg::FSUM_W-1:0] fnext [3];
	logic signed [cmeu_pkg::PSUM_W-1:0] pnext;
	logic signed [31:0] fv [3];
	logic signed [31:0] nv [3];
	logic signed [63:0] prod [3];
	logic signed [cmeu_pkg::PSUM_W+9:0] pwide;
	logic signed [cmeu_pkg::FSUM_W:0] fw [3];
	logic take;

	function automatic logic signed [cmeu_pkg::FSUM_W-1:0] sat_f(
		input logic signed [cmeu_pkg::FSUM_W:0] x);
		if (x[cmeu_pkg::FSUM_W] != x[cmeu_pkg::FSUM_W-1])
			return {x[cmeu_pkg::FSUM_W], {(cmeu_pkg::FSUM_W-1){~x[cmeu_pkg::FSUM_W]}}};
		return x[cmeu_pkg::FSUM_W-1:0];
	endfunction

	assign in_ch.ready = ~in_ch.data.last_corner | ~job_valid | job_ready;
	assign take = in_ch.valid & in_ch.ready;

	always_comb begin
		fv[0] = in_ch.data.force_x;
		fv[1] = in_ch.data.force_y;
		fv[2] = in_ch.data.force_z;
		nv[0] = in_ch.data.node_vel_x;
		nv[1] = in_ch.data.node_vel_y;
		nv[2] = in_ch.data.node_vel_z;
		for (int i = 0; i < 3; i++) begin
			prod[i] = fv[i] * nv[i];
			fw[i] = {fsum_q[i][cmeu_pkg::FSUM_W-1], fsum_q[i]}
				+ {{(cmeu_pkg::FSUM_W-31){fv[i][31]}}, fv[i]};
			fnext[i] = sat_f(fw[i]);
		end
		pwide = {{10{psum_q[cmeu_pkg::PSUM_W-1]}}, psum_q}
			+ {{2{prod[0][63]}}, prod[0][63:16]}
			+ {{2{prod[1][63]}}, prod[1][63:16]}
			+ {{2{prod[2][63]}}, prod[2][63:16]};
		if (pwide > $signed({11'b0, {(cmeu_pkg::PSUM_W-1){1'b1}}}))
			pnext = {1'b0, {(cmeu_pkg::PSUM_W-1){1'b1}}};
		else if (pwide < $signed({11'h7ff, {(cmeu_pkg::PSUM_W-1){1'b0}}}))
			pnext = {1'b1, {(cmeu_pkg::PSUM_W-1){1'b0}}};
		else
			pnext = pwide[cmeu_pkg::PSUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsum_q <= '{default: '0};
			psum_q <= '0;
			job_valid <= 1'b0;
		end else begin
			if (take && in_ch.data.last_corner) job_valid <= 1'b1;
			else if (job_ready) job_valid <= 1'b0;
			if (take) begin
				if (in_ch.data.last_corner) begin
					fsum_q <= '{default: '0};
					psum_q <= '0;
				end else begin
					fsum_q <= fnext;
					psum_q <= pnext;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_ch.data.last_corner) begin
			job.fsum_x <= fnext[0];
			job.fsum_y <= fnext[1];
			job.fsum_z <= fnext[2];
			job.psum <= pnext;
			job.mass <= (in_ch.data.cell_mass == '0) ? cmeu_pkg::MASS_W'(1)
				: in_ch.data.cell_mass;
			job.old_vel_x <= in_ch.data.old_vel_x;
			job.old_vel_y <= in_ch.data.old_vel_y;
			job.old_vel_z <= in_ch.data.old_vel_z;
			job.old_te <= in_ch.data.old_total_energy;
		end
	end
endmodule

### design/cmeu_back.sv
// Back end: serial divide, weight, updates and energies for one element.
module cmeu_back (
	input  logic clk,
	input  logic arst_n,
	input  logic [cmeu_pkg::SW_W-1:0] stage_weight,
	input  logic [cmeu_pkg::DT_W-1:0] time_step,
	input  logic job_valid,
	output logic job_ready,
	input  cmeu_pkg::job_t job,
	cmeu_result_if.source out_ch
);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DIV = 4'd1;
	localparam logic [3:0] ST_W = 4'd2;
	localparam logic [3:0] ST_MUL = 4'd3;
	localparam logic [3:0] ST_ADD = 4'd4;
	localparam logic [3:0] ST_SQ = 4'd5;
	localparam logic [3:0] ST_KE = 4'd6;
	localparam logic [3:0] ST_IE = 4'd7;
	localparam logic [3:0] ST_OUT = 4'd8;
	localparam int unsigned NUM_W = 47;

	logic [3:0] state_q;
	cmeu_pkg::job_t job_q;
	logic [NUM_W-1:0] quo_q;
	logic [cmeu_pkg::MASS_W:0] rem_q;
	logic [5:0] cnt_q;
	logic [63:0] w_q;
	logic [1:0] lane_q;
	logic [1:0] half_q;
	logic [cmeu_pkg::PSUM_W-1:0] mag_q;
	logic neg_q;
	logic [71:0] plo_q;
	logic [71:0] acc_q;
	logic signed [31:0] res_q [4];
	logic [65:0] ke_q;
	logic [31:0] ke_out_q;

	logic [cmeu_pkg::MASS_W:0] rtry;
	logic [NUM_W-1:0] num;
	logic [1:0] lane_nx;
	logic signed [cmeu_pkg::PSUM_W-1:0] src;
	logic [71:0] pp;
	logic [72:0] full;
	logic [40:0] dmag;
	logic signed [42:0] sum;
	logic signed [31:0] nvs;
	logic [31:0] nvm;
	logic signed [33:0] iew;

	assign num = {time_step, 16'd0};
	assign rtry = {rem_q[cmeu_pkg::MASS_W-1:0], num[6'(NUM_W-1) - cnt_q]};
	assign job_ready = (state_q == ST_IDLE);
	assign lane_nx = lane_q + 2'd1;

	always_comb begin
		case (lane_nx)
			2'd0: src = {{4{job_q.fsum_x[35]}}, job_q.fsum_x};
			2'd1: src = {{4{job_q.fsum_y[35]}}, job_q.fsum_y};
			2'd2: src = {{4{job_q.fsum_z[35]}}, job_q.fsum_z};
			default: src = job_q.psum;
		endcase
	end

	// 40x64 product split into two 32-bit halves of w
	assign pp = {32'd0, mag_q} * (half_q[0] ? {40'd0, w_q[63:32]} : {40'd0, w_q[31:0]});
	assign full = {1'b0, plo_q} + {1'b0, acc_q[39:0], 32'd0};
	assign dmag = (acc_q[71:40] != '0 || full[72:16] > 57'h100_0000_0000)
		? 41'h100_0000_0000 : full[56:16];

	always_comb begin
		case (lane_q)
			2'd0: sum = {{11{job_q.old_vel_x[31]}}, job_q.old_vel_x};
			2'd1: sum = {{11{job_q.old_vel_y[31]}}, job_q.old_vel_y};
			2'd2: sum = {{11{job_q.old_vel_z[31]}}, job_q.old_vel_z};
			default: sum = {{11{job_q.old_te[31]}}, job_q.old_te};
		endcase
		sum = neg_q ? sum - $signed({2'b0, dmag}) : sum + $signed({2'b0, dmag});
		if (sum > 43'sd2147483647) nvs = 32'h7fff_ffff;
		else if (sum < -43'sd2147483648) nvs = 32'h8000_0000;
		else nvs = sum[31:0];
		nvm = res_q[lane_q][31] ? 32'(-res_q[lane_q]) : res_q[lane_q];
		iew = {{2{res_q[3][31]}}, res_q[3]} - {2'b0, ke_out_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_ch.valid <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (job_valid) state_q <= ST_DIV;
				ST_DIV: if (cnt_q == 6'(NUM_W-1)) state_q <= ST_W;
				ST_W: state_q <= ST_MUL;
				ST_MUL: if (half_q == 2'd2) state_q <= ST_ADD;
				ST_ADD: state_q <= (lane_q == 2'd3) ? ST_SQ : ST_MUL;
				ST_SQ: if (lane_q == 2'd2) state_q <= ST_KE;
				ST_KE: state_q <= ST_IE;
				ST_IE: begin
					state_q <= ST_OUT;
					out_ch.valid <= 1'b1;
				end
				ST_OUT: if (out_ch.ready) begin
					out_ch.valid <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				job_q <= job;
				cnt_q <= '0;
				rem_q <= '0;
				quo_q <= '0;
			end
			ST_DIV: begin
				cnt_q <= cnt_q + 6'd1;
				if (rtry >= {1'b0, job_q.mass}) begin
					rem_q <= rtry - {1'b0, job_q.mass};
					quo_q <= {quo_q[NUM_W-2:0], 1'b1};
				end else begin
					rem_q <= rtry;
					quo_q <= {quo_q[NUM_W-2:0], 1'b0};
				end
			end
			ST_W: begin
				w_q <= 64'((({47'd0, stage_weight} * {17'd0, quo_q}) >> 16));
				lane_q <= 2'd0;
				half_q <= 2'd0;
				mag_q <= job_q.fsum_x[35] ? 40'(-{{4{1'b1}}, job_q.fsum_x})
					: {4'd0, job_q.fsum_x};
				neg_q <= job_q.fsum_x[35];
			end
			ST_MUL: begin
				half_q <= half_q + 2'd1;
				if (half_q == 2'd0) plo_q <= pp;
				else if (half_q == 2'd1) acc_q <= pp;
			end
			ST_ADD: begin
				res_q[lane_q] <= nvs;
				lane_q <= lane_nx;
				half_q <= 2'd0;
				mag_q <= src[39] ? 40'(-src) : src;
				neg_q <= src[39];
				if (lane_q == 2'd3) ke_q <= '0;
			end
			ST_SQ: begin
				ke_q <= ke_q + {2'd0, 64'({32'd0, nvm} * {32'd0, nvm})};
				lane_q <= lane_q + 2'd1;
			end
			ST_KE: ke_out_q <= (ke_q[65:17] > 49'h7fff_ffff) ? 32'h7fff_ffff
				: ke_q[48:17];
			ST_IE: begin
				out_ch.data.new_vel_x <= res_q[0];
				out_ch.data.new_vel_y <= res_q[1];
				out_ch.data.new_vel_z <= res_q[2];
				out_ch.data.new_total_energy <= res_q[3];
				out_ch.data.cell_power_out <=
					(job_q.psum > 40'sd2147483647) ? 32'h7fff_ffff
					: (job_q.psum < -40'sd2147483648) ? 32'h8000_0000
					: job_q.psum[31:0];
				out_ch.data.kinetic_energy <= ke_out_q[30:0];
				out_ch.data.internal_energy <=
					(iew < -34'sd2147483648) ? 32'h8000_0000 : iew[31:0];
			end
			default: ;
		endcase
	end
endmodule

### tb/cell_momentum_energy_update_core_test.sv
// Testbench: corner streams with random gaps, checked against an in-bench element update predictor.
module cell_momentum_energy_update_core_test;
	localparam int CYCLE_LIMIT = 400000;
	localparam int BACK_END_CYCLES = 120;
	localparam bit [127:0] DELTA_CAP = 128'd1 << 40;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [cmeu_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [cmeu_pkg::CFG_W-1:0] cfg_data;

	cmeu_corner_if in_ch();
	cmeu_result_if out_ch();

	cell_momentum_energy_update_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	bit [63:0] weight_q;
	bit [63:0] step_q;
	longint force_acc [3];
	longint power_acc;
	cmeu_pkg::result_t cell_updates_q[$];

	int errors;
	int cycles;
	int corners_sent;
	int cells_checked;
	int configs_written;
	bit sender_idles;
	bit sink_idles;
	int hold_off_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				cell_updates_q.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic longint clamp_bits(longint x, int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) << (bits - 1)) - 1;
		lo = -hi - 1;
		if (x > hi)
			return hi;
		if (x < lo)
			return lo;
		return x;
	endfunction

	function automatic longint weighted_delta(bit [63:0] w, longint s);
		bit [63:0] a;
		bit [127:0] p;
		bit [127:0] m;
		a = (s < 0) ? -s : s;
		p = {64'd0, w} * {64'd0, a};
		m = p >> 16;
		if (m > DELTA_CAP)
			m = DELTA_CAP;
		return (s < 0) ? -longint'(m[63:0]) : longint'(m[63:0]);
	endfunction

	task automatic predict_corner(input cmeu_pkg::corner_t c);
		longint f [3];
		longint v [3];
		longint ov [3];
		longint pterm;
		longint nv;
		longint te;
		longint ke;
		bit [63:0] mass;
		bit [63:0] w;
		bit [63:0] mag;
		bit [63:0] ksq;
		cmeu_pkg::result_t r;
		f[0] = longint'(c.force_x);
		f[1] = longint'(c.force_y);
		f[2] = longint'(c.force_z);
		v[0] = longint'(c.node_vel_x);
		v[1] = longint'(c.node_vel_y);
		v[2] = longint'(c.node_vel_z);
		ov[0] = longint'(c.old_vel_x);
		ov[1] = longint'(c.old_vel_y);
		ov[2] = longint'(c.old_vel_z);
		pterm = 0;
		for (int i = 0; i < 3; i++) begin
			force_acc[i] = clamp_bits(force_acc[i] + f[i], cmeu_pkg::FSUM_W);
			pterm += (f[i] * v[i]) >>> 16;
		end
		power_acc = clamp_bits(power_acc + pterm, cmeu_pkg::PSUM_W);
		if (!c.last_corner)
			return;
		mass = 64'(c.cell_mass);
		if (mass == 0)
			mass = 1;
		w = (weight_q * ((step_q << 16) / mass)) >> 16;
		ksq = 0;
		for (int i = 0; i < 3; i++) begin
			nv = clamp_bits(ov[i] + weighted_delta(w, force_acc[i]), cmeu_pkg::WORD_W);
			mag = (nv < 0) ? -nv : nv;
			ksq += mag * mag;
			if (i == 0) r.new_vel_x = nv[31:0];
			else if (i == 1) r.new_vel_y = nv[31:0];
			else r.new_vel_z = nv[31:0];
		end
		te = clamp_bits(longint'(c.old_total_energy) + weighted_delta(w, power_acc),
			cmeu_pkg::WORD_W);
		ksq = ksq >> 17;
		ke = (ksq > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : longint'(ksq);
		r.new_total_energy = te[31:0];
		r.cell_power_out = 32'(clamp_bits(power_acc, cmeu_pkg::WORD_W));
		r.kinetic_energy = ke[30:0];
		r.internal_energy = 32'(clamp_bits(te - ke, cmeu_pkg::WORD_W));
		cell_updates_q.push_back(r);
		for (int i = 0; i < 3; i++)
			force_acc[i] = 0;
		power_acc = 0;
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		errors++;
		$display("mismatch in %s at cycle %0d: got %0d, expected %0d", what, cycles, got, want);
	endtask

	// result sink: random stalls, optional long hold-off, field compare
	initial begin
		cmeu_pkg::result_t want;
		int stall;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = sink_idles ? $urandom_range(0, 11) : 0;
			if (hold_off_cycles > 0) begin
				stall = hold_off_cycles;
				hold_off_cycles = 0;
			end
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			if (cell_updates_q.size() == 0) begin
				errors++;
				$display("unexpected result transfer at cycle %0d", cycles);
			end else begin
				want = cell_updates_q.pop_front();
				cells_checked++;
				if (out_ch.data.new_vel_x !== want.new_vel_x)
					report_mismatch("new_vel_x", out_ch.data.new_vel_x, want.new_vel_x);
				if (out_ch.data.new_vel_y !== want.new_vel_y)
					report_mismatch("new_vel_y", out_ch.data.new_vel_y, want.new_vel_y);
				if (out_ch.data.new_vel_z !== want.new_vel_z)
					report_mismatch("new_vel_z", out_ch.data.new_vel_z, want.new_vel_z);
				if (out_ch.data.new_total_energy !== want.new_total_energy)
					report_mismatch("new_total_energy", out_ch.data.new_total_energy,
						want.new_total_energy);
				if (out_ch.data.cell_power_out !== want.cell_power_out)
					report_mismatch("cell_power_out", out_ch.data.cell_power_out,
						want.cell_power_out);
				if (out_ch.data.kinetic_energy !== want.kinetic_energy)
					report_mismatch("kinetic_energy", out_ch.data.kinetic_energy,
						want.kinetic_energy);
				if (out_ch.data.internal_energy !== want.internal_energy)
					report_mismatch("internal_energy", out_ch.data.internal_energy,
						want.internal_energy);
			end
		end
	end

	task automatic send_corner(input cmeu_pkg::corner_t c);
		int gap;
		gap = sender_idles ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= c;
		do @(posedge clk); while (!in_ch.ready);
		predict_corner(c);
		corners_sent++;
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (cell_updates_q.size() != 0)
			@(posedge clk);
		repeat (BACK_END_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [cmeu_pkg::CFG_IDX_W-1:0] idx,
		input bit [63:0] value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value[cmeu_pkg::CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == cmeu_pkg::REG_STAGE_WEIGHT)
			weight_q = value & 64'h1FFFF;
		else
			step_q = value & 64'h7FFF_FFFF;
		configs_written++;
	endtask

	task automatic set_config(input bit [63:0] sw, input bit [63:0] dt);
		wait_idle();
		write_reg(cmeu_pkg::REG_STAGE_WEIGHT, sw);
		write_reg(cmeu_pkg::REG_TIME_STEP, dt);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			2: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
			3: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
			default: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
		endcase
	endfunction

	function automatic logic [30:0] rand_mass();
		case ($urandom_range(0, 4))
			0: return 31'($urandom);
			1: return 31'($urandom_range(0, 4));
			2: return 31'h7FFF_FFFF;
			default: return 31'($urandom_range(1 << 12, 1 << 22));
		endcase
	endfunction

	function automatic cmeu_pkg::corner_t rand_corner(input bit last);
		cmeu_pkg::corner_t c;
		c.force_x = rand_word();
		c.force_y = rand_word();
		c.force_z = rand_word();
		c.node_vel_x = rand_word();
		c.node_vel_y = rand_word();
		c.node_vel_z = rand_word();
		c.cell_mass = rand_mass();
		c.old_vel_x = rand_word();
		c.old_vel_y = rand_word();
		c.old_vel_z = rand_word();
		c.old_total_energy = rand_word();
		c.last_corner = last;
		return c;
	endfunction

	task automatic send_cell(input int corners);
		for (int i = 1; i <= corners; i++)
			send_corner(rand_corner(i == corners));
	endtask

	task automatic test_directed_extremes();
		cmeu_pkg::corner_t c;
		c = '0;
		c.last_corner = 1'b1;
		send_corner(c);
		c.cell_mass = 31'h7FFF_FFFF;
		c.old_vel_x = 32'h7FFF_FFFF;
		c.old_vel_y = 32'h8000_0000;
		c.old_vel_z = 32'h7FFF_FFFF;
		c.old_total_energy = 32'h8000_0000;
		send_corner(c);
		c = '1;
		c.force_x = 32'h7FFF_FFFF;
		c.force_y = 32'h8000_0000;
		c.node_vel_x = 32'h7FFF_FFFF;
		c.node_vel_y = 32'h8000_0000;
		c.cell_mass = 31'd1;
		send_corner(c);
		// power sum and force sums run into their limits
		c = '0;
		c.force_x = 32'h7FFF_FFFF;
		c.force_y = 32'h8000_0000;
		c.force_z = 32'h7FFF_FFFF;
		c.node_vel_x = 32'h7FFF_FFFF;
		c.node_vel_y = 32'h8000_0000;
		c.node_vel_z = 32'h7FFF_FFFF;
		repeat (17) send_corner(c);
		c.last_corner = 1'b1;
		c.cell_mass = 31'd0;
		send_corner(c);
		c.force_x = 32'h8000_0000;
		c.force_y = 32'h7FFF_FFFF;
		c.node_vel_y = 32'h7FFF_FFFF;
		c.node_vel_x = 32'h7FFF_FFFF;
		c.cell_mass = 31'h7FFF_FFFF;
		c.old_total_energy = 32'h7FFF_FFFF;
		send_corner(c);
		c = '0;
		c.force_x = 32'h0001_0000;
		c.node_vel_x = 32'hFFFF_8000;
		c.cell_mass = 31'h0001_0000;
		c.old_vel_x = 32'h0002_0000;
		c.old_total_energy = 32'h0003_0000;
		c.last_corner = 1'b1;
		send_corner(c);
	endtask

	task automatic test_register_extremes();
		set_config(64'd65536 * 2 - 1, 64'h7FFF_FFFF);
		send_cell(1);
		send_cell(3);
		set_config(64'd0, 64'd0);
		send_cell(2);
		set_config(64'd65536, 64'd1);
		send_cell(4);
		set_config(64'd1, 64'h7FFF_FFFF);
		send_cell(1);
	endtask

	task automatic test_random_cells(input int items, input bit long_hold);
		int target;
		target = corners_sent + items;
		if (long_hold) begin
			sender_idles = 1'b0;
			hold_off_cycles = 400;
		end
		while (corners_sent < target) begin
			if ($urandom_range(0, 9) == 0)
				send_cell($urandom_range(9, 24));
			else
				send_cell($urandom_range(1, 8));
			if (!long_hold && $urandom_range(0, 19) == 0) begin
				sender_idles = !sender_idles;
				sink_idles = $urandom_range(0, 1);
			end
		end
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		corners_sent = 0;
		cells_checked = 0;
		configs_written = 0;
		hold_off_cycles = 0;
		sender_idles = 1'b0;
		sink_idles = 1'b0;
		weight_q = 64'd65536;
		step_q = 64'd65536;
		for (int i = 0; i < 3; i++)
			force_acc[i] = 0;
		power_acc = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_extremes();
		test_register_extremes();
		set_config(64'd65536, 64'd65536);
		sender_idles = 1'b1;
		sink_idles = 1'b1;
		test_random_cells(160, 1'b0);
		set_config($urandom_range(0, 131071), $urandom_range(1, 1 << 20));
		test_random_cells(160, 1'b1);
		sender_idles = 1'b1;
		set_config(64'd32768, $urandom);
		test_random_cells(160, 1'b0);
		set_config($urandom_range(0, 65536), $urandom_range(0, 1 << 16));
		test_random_cells(160, 1'b0);

		wait_idle();
		$display("covered %0d corners, %0d element results, %0d register writes",
			corners_sent, cells_checked, configs_written);
		$display("including saturated sums, zero mass, weights above one and a long sink stall");
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
